>>> rtl/swarq_pkg.sv
// Shared types and constants for the sliding-window ARQ sender.
`default_nettype none
package swarq_pkg;

    localparam int SEQ_BITS_DEF   = 16;
    localparam int WINDOW_MAX_DEF = 16;

    localparam int SEQ_FIELD_W  = 16;
    localparam int SLID_FIELD_W = 5;
    localparam int MODE_W       = 2;
    localparam int WSIZE_W      = 5;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 5;
    localparam int OUT_DATA_W   = 40;

    localparam logic [MODE_W-1:0] MODE_GBN  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SAW  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SR   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam logic OP_SEND = 1'b0;
    localparam logic OP_ACK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd1;

    localparam logic [WSIZE_W-1:0] WSIZE_RESET = 5'd4;

    // Row-wide control for the slot cells
    typedef struct packed {
        logic clear;
        logic shift;
    } cell_ctrl_t;

endpackage
`default_nettype wire

>>> rtl/sliding_window_arq_sender.sv
// Sliding-window ARQ sender: go-back-n, stop-and-wait and selective-repeat window tracker.
// Steps: the item is captured, evaluated in ST_EVAL and, for a selective-repeat ack, the
//   base slides one slot per cycle through the slot cells (up to WINDOW_MAX) in ST_SLIDE;
//   ST_HOLD then loads the result into the output register, waiting while it is stalled.
// Throughput: one item at a time; the next item is taken only once the result is loaded.
// Reset (rst_n, async, active low): go-back-n mode, window size 4, base = next = 1, all
//   slots cleared, no result pending. A mode write restarts (go-back-n 1, others 0).
`default_nettype none
module sliding_window_arq_sender #(
    parameter int SEQ_BITS   = swarq_pkg::SEQ_BITS_DEF,
    parameter int WINDOW_MAX = swarq_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // input stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    input  wire logic [swarq_pkg::SEQ_FIELD_W-1:0]    s_axis_tdata,  // [15:0] sequence_number
    input  wire logic                                 s_axis_tuser,  // [0] operation
    // result stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    output logic [swarq_pkg::OUT_DATA_W-1:0]          m_axis_tdata,  // [15:0] window_base,
                                                                     // [31:16] next_to_send,
                                                                     // [36:32] slid_count,
                                                                     // [39:37] zero
    output logic                                      m_axis_tuser,  // [0] granted
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [swarq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [swarq_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import swarq_pkg::*;

    // Largest usable window: WINDOW_MAX, and below the sequence space size
    localparam int SEQ_CAP = (SEQ_BITS >= 7) ? 127 : ((1 << SEQ_BITS) - 1);
    localparam int WIN_CAP = (WINDOW_MAX < SEQ_CAP) ? WINDOW_MAX : SEQ_CAP;
    localparam int IDX_W   = $clog2(WINDOW_MAX);
    localparam int OFF_W0  = (SEQ_BITS > IDX_W) ? SEQ_BITS : IDX_W;
    localparam int OFF_W   = (OFF_W0 > SLID_FIELD_W) ? OFF_W0 : SLID_FIELD_W;
    localparam int CNT_W0  = $clog2(WINDOW_MAX + 1);
    localparam int CNT_W   = (CNT_W0 > SLID_FIELD_W) ? CNT_W0 : SLID_FIELD_W;
    localparam int EXT_W   = (SEQ_BITS > SEQ_FIELD_W) ? SEQ_BITS : SEQ_FIELD_W;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for an item
    localparam logic [1:0] ST_EVAL  = 2'd1;  // window decision
    localparam logic [1:0] ST_SLIDE = 2'd2;  // selective repeat: slide over acked slots
    localparam logic [1:0] ST_HOLD  = 2'd3;  // hand result to the output register

    logic [1:0]            state_reg, state_next;
    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic [WSIZE_W-1:0]    wsize_reg, wsize_next;
    logic [SEQ_BITS-1:0]   base_reg, base_next;
    logic [SEQ_BITS-1:0]   next_reg, next_next;
    logic                  op_reg, op_next;
    logic [SEQ_BITS-1:0]   seq_reg, seq_next;
    logic                  grant_reg, grant_next;
    logic [CNT_W-1:0]      slid_reg, slid_next;

    logic                  out_valid_reg, out_valid_next;
    logic                  out_grant_reg, out_grant_next;
    logic [SEQ_FIELD_W-1:0] out_base_reg, out_base_next;
    logic [SEQ_FIELD_W-1:0] out_nxt_reg, out_nxt_next;
    logic [SLID_FIELD_W-1:0] out_slid_reg, out_slid_next;

    // Slot cell row
    cell_ctrl_t            cell_ctrl;
    logic [WINDOW_MAX-1:0] cell_set;
    logic [WINDOW_MAX-1:0] acked;

    logic in_xfer, cfg_xfer, mode_wr, out_load;
    logic [SEQ_BITS-1:0]   restart_seq;
    logic [SEQ_BITS-1:0]   win;
    logic [SEQ_BITS-1:0]   off;
    logic [SEQ_BITS-1:0]   outstanding;
    logic [OFF_W-1:0]      off_ext;
    logic [OFF_W-1:0]      off_plus;
    logic [IDX_W-1:0]      off_idx;
    logic                  in_win;
    logic                  sr_ack_hit;
    logic [EXT_W-1:0]      base_ext, next_ext;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign cfg_xfer      = cfg_valid && cfg_ready;
    assign mode_wr       = cfg_xfer && (cfg_index == REG_MODE);
    assign restart_seq   = (cfg_data[MODE_W-1:0] == MODE_GBN) ? SEQ_BITS'(1) : '0;

    // Clamped window
    always_comb
    begin
        if (wsize_reg == '0)
        begin
            win = SEQ_BITS'(1);
        end
        else if (32'(wsize_reg) > WIN_CAP)
        begin
            win = SEQ_BITS'(WIN_CAP);
        end
        else
        begin
            win = SEQ_BITS'(wsize_reg);
        end
    end

    // Modular distances from the base
    assign off         = seq_reg - base_reg;
    assign outstanding = next_reg - base_reg;
    assign off_ext     = OFF_W'(off);
    assign off_plus    = off_ext + OFF_W'(1);
    assign off_idx     = off_ext[IDX_W-1:0];
    assign in_win      = (off < win);
    assign sr_ack_hit  = (state_reg == ST_EVAL) && (mode_reg == MODE_SR)
                         && (op_reg == OP_ACK) && in_win;

    always_comb
    begin
        for (int k = 0; k < WINDOW_MAX; k++)
        begin
            cell_set[k] = sr_ack_hit && (off_idx == IDX_W'(k));
        end
    end

    assign cell_ctrl.clear = mode_wr;
    assign cell_ctrl.shift = (state_reg == ST_SLIDE) && acked[0]
                             && (slid_reg < CNT_W'(WINDOW_MAX));

    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++)
        begin : g_cell
            logic from_right;
            if (g == WINDOW_MAX - 1)
            begin : g_last
                assign from_right = 1'b0;
            end
            else
            begin : g_inner
                assign from_right = acked[g+1];
            end
            swarq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (cell_ctrl),
                .set        (cell_set[g]),
                .from_right (from_right),
                .acked      (acked[g])
            );
        end
    endgenerate

    assign out_load = (state_reg == ST_HOLD) && (!out_valid_reg || m_axis_tready);
    assign base_ext = EXT_W'(base_reg);
    assign next_ext = EXT_W'(next_reg);

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        wsize_next = wsize_reg;
        base_next  = base_reg;
        next_next  = next_reg;
        op_next    = op_reg;
        seq_next   = seq_reg;
        grant_next = grant_reg;
        slid_next  = slid_reg;

        // Configuration is to be written only while idle; the block itself does not enforce it
        if (cfg_xfer)
        begin
            case (cfg_index)
                REG_MODE:
                begin
                    mode_next = cfg_data[MODE_W-1:0];
                    base_next = restart_seq;
                    next_next = restart_seq;
                end
                REG_WINDOW:
                begin
                    wsize_next = cfg_data[WSIZE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    op_next    = s_axis_tuser;
                    seq_next   = SEQ_BITS'(s_axis_tdata);
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                grant_next = 1'b0;
                slid_next  = '0;
                state_next = ST_HOLD;
                case (mode_reg)
                    MODE_GBN:
                    begin
                        if (op_reg == OP_SEND)
                        begin
                            if (outstanding < win)
                            begin
                                grant_next = 1'b1;
                                next_next  = next_reg + SEQ_BITS'(1);
                            end
                        end
                        else if (off < outstanding)
                        begin
                            grant_next = 1'b1;
                            slid_next  = CNT_W'(off_plus[SLID_FIELD_W-1:0]);
                            base_next  = seq_reg + SEQ_BITS'(1);
                        end
                    end
                    MODE_SAW:
                    begin
                        if (seq_reg == base_reg)
                        begin
                            grant_next = 1'b1;
                            if (op_reg == OP_ACK)
                            begin
                                base_next = base_reg + SEQ_BITS'(1);
                                slid_next = CNT_W'(1);
                            end
                        end
                    end
                    MODE_SR:
                    begin
                        if (in_win)
                        begin
                            if (op_reg == OP_SEND)
                            begin
                                grant_next = !acked[off_idx];
                            end
                            else
                            begin
                                grant_next = 1'b1;
                                state_next = ST_SLIDE;
                            end
                        end
                    end
                    default:
                    begin
                        // unused mode: refuse everything
                    end
                endcase
            end
            ST_SLIDE:
            begin
                if (cell_ctrl.shift)
                begin
                    base_next = base_reg + SEQ_BITS'(1);
                    slid_next = slid_reg + CNT_W'(1);
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_grant_next = out_grant_reg;
        out_base_next  = out_base_reg;
        out_nxt_next   = out_nxt_reg;
        out_slid_next  = out_slid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_grant_next = grant_reg;
            out_base_next  = base_ext[SEQ_FIELD_W-1:0];
            out_nxt_next   = next_ext[SEQ_FIELD_W-1:0];
            out_slid_next  = slid_reg[SLID_FIELD_W-1:0];
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_GBN;
            wsize_reg     <= WSIZE_RESET;
            base_reg      <= SEQ_BITS'(1);
            next_reg      <= SEQ_BITS'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            wsize_reg     <= wsize_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        seq_reg       <= seq_next;
        grant_reg     <= grant_next;
        slid_reg      <= slid_next;
        out_grant_reg <= out_grant_next;
        out_base_reg  <= out_base_next;
        out_nxt_reg   <= out_nxt_next;
        out_slid_reg  <= out_slid_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_grant_reg;
    assign m_axis_tdata  = {3'b000, out_slid_reg, out_nxt_reg, out_base_reg};

    // A mode write empties every slot
    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        mode_wr |=> (acked == '0))
        else $error("slot cells not cleared on restart");

    // The base moves only during evaluation, sliding or a mode write
    a_base_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_EVAL && state_reg != ST_SLIDE && !mode_wr) |=> $stable(base_reg))
        else $error("window base moved outside its update states");

    // Stop-and-wait never advances the next-to-send counter
    a_saw_next: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SAW) |-> (next_reg == '0))
        else $error("next counter moved in stop-and-wait");

    // Sliding stops with the front slot unacknowledged or the count at its limit
    a_slide_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SLIDE && !cell_ctrl.shift) |->
        (!acked[0] || slid_reg == CNT_W'(WINDOW_MAX)))
        else $error("slide ended early");

endmodule
`default_nettype wire

>>> rtl/swarq_cell.sv
// One selective-repeat slot cell: an acknowledged bit that shifts toward the base.
`default_nettype none
module swarq_cell (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire swarq_pkg::cell_ctrl_t ctrl,
    input  wire logic                  set,
    input  wire logic                  from_right,
    output logic                       acked
);
    import swarq_pkg::*;

    logic acked_reg;
    logic acked_next;

    always_comb
    begin
        acked_next = acked_reg;
        if (ctrl.clear)
        begin
            acked_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            acked_next = from_right;
        end
        else if (set)
        begin
            acked_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acked_reg <= 1'b0;
        end
        else
        begin
            acked_reg <= acked_next;
        end
    end

    assign acked = acked_reg;

endmodule
`default_nettype wire

>>> tb/sv/swarq_window_checker.sv
// Scoreboard for the ARQ sender: tracks window state on every transfer and checks each result.
`default_nettype none
module swarq_window_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    input  wire logic [swarq_pkg::SEQ_FIELD_W-1:0] s_axis_tdata,
    input  wire logic                              s_axis_tuser,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    input  wire logic [swarq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  wire logic                              m_axis_tuser,
    input  wire logic                              cfg_valid,
    input  wire logic                              cfg_ready,
    input  wire logic [swarq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [swarq_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic [swarq_pkg::SEQ_FIELD_W-1:0]      window_base_now,
    output int                                     results_pending,
    output int                                     mismatch_count
);
    import swarq_pkg::*;

    localparam int NEXT_LSB   = SEQ_FIELD_W;
    localparam int SLID_LSB   = 2 * SEQ_FIELD_W;

    typedef struct packed {
        logic                    granted;
        logic [SEQ_FIELD_W-1:0]  base;
        logic [SEQ_FIELD_W-1:0]  to_send;
        logic [SLID_FIELD_W-1:0] slid;
    } window_report_t;

    logic [MODE_W-1:0]         mode_q;
    logic [WSIZE_W-1:0]        wsize_q;
    logic [SEQ_FIELD_W-1:0]    base_q;
    logic [SEQ_FIELD_W-1:0]    next_q;
    logic [WINDOW_MAX_DEF-1:0] acked_q;   // bit k: base_q + k acknowledged
    window_report_t            reports_due[$];

    task automatic restart_window();
        base_q  = (mode_q == MODE_GBN) ? SEQ_FIELD_W'(1) : '0;
        next_q  = base_q;
        acked_q = '0;
    endtask

    function automatic window_report_t advance_window(input logic op,
                                                      input logic [SEQ_FIELD_W-1:0] seq);
        window_report_t         r;
        logic [SEQ_FIELD_W-1:0] off;
        logic [SEQ_FIELD_W-1:0] in_flight;
        int                     win;
        int                     slid;
        win = int'(wsize_q);
        if (win < 1)
            win = 1;
        if (win > WINDOW_MAX_DEF)
            win = WINDOW_MAX_DEF;
        off       = seq - base_q;
        in_flight = next_q - base_q;
        slid      = 0;
        r.granted = 1'b0;
        case (mode_q)
            MODE_GBN:
            begin
                if (op == OP_SEND)
                begin
                    if (int'(in_flight) < win)
                    begin
                        r.granted = 1'b1;
                        next_q    = next_q + 1'b1;
                    end
                end
                else if (off < in_flight)
                begin
                    // cumulative ack
                    r.granted = 1'b1;
                    slid      = int'(off) + 1;
                    base_q    = seq + 1'b1;
                end
            end
            MODE_SAW:
            begin
                if (seq == base_q)
                begin
                    r.granted = 1'b1;
                    if (op == OP_ACK)
                    begin
                        base_q = base_q + 1'b1;
                        slid   = 1;
                    end
                end
            end
            MODE_SR:
            begin
                if (int'(off) < win)
                begin
                    if (op == OP_SEND)
                        r.granted = !acked_q[off];
                    else
                    begin
                        r.granted    = 1'b1;
                        acked_q[off] = 1'b1;
                        while (acked_q[0] && slid < WINDOW_MAX_DEF)
                        begin
                            acked_q = acked_q >> 1;
                            base_q  = base_q + 1'b1;
                            slid++;
                        end
                    end
                end
            end
            default:
                ;   // unused mode: everything refused
        endcase
        r.base    = base_q;
        r.to_send = next_q;
        r.slid    = SLID_FIELD_W'(slid);
        return r;
    endfunction

    task automatic compare_field(input string what, input logic [SEQ_FIELD_W-1:0] want,
                                 input logic [SEQ_FIELD_W-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s differs, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // Config, then the input transfer, then the result: a result never belongs to an
    // item taken at the same edge, and the oldest expectation is popped regardless.
    always @(posedge clk or negedge rst_n)
    begin : track
        window_report_t want;
        if (!rst_n)
        begin
            mode_q  = MODE_GBN;
            wsize_q = WSIZE_RESET;
            restart_window();
            reports_due.delete();
            mismatch_count = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MODE)
                begin
                    mode_q = cfg_data[MODE_W-1:0];
                    restart_window();
                end
                else if (cfg_index == REG_WINDOW)
                    wsize_q = cfg_data[WSIZE_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                reports_due.insert(reports_due.size(),
                                   advance_window(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (reports_due.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: result with none expected, expected nothing, actual %h/%b",
                             $time, m_axis_tdata, m_axis_tuser);
                end
                else
                begin
                    want = reports_due.pop_front();
                    compare_field("granted", SEQ_FIELD_W'(want.granted),
                                  SEQ_FIELD_W'(m_axis_tuser));
                    compare_field("window_base", want.base, m_axis_tdata[NEXT_LSB-1:0]);
                    compare_field("next_to_send", want.to_send,
                                  m_axis_tdata[SLID_LSB-1:NEXT_LSB]);
                    compare_field("slid_count", SEQ_FIELD_W'(want.slid),
                                  SEQ_FIELD_W'(m_axis_tdata[SLID_LSB+SLID_FIELD_W-1:SLID_LSB]));
                end
            end
        end
        window_base_now = base_q;
        results_pending = reports_due.size();
    end

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// Top of the ARQ sender testbench: clock, reset, stimulus, result sink, watchdog and verdict.
`default_nettype none
module testbench;
    import swarq_pkg::*;

    localparam int ITEM_TARGET    = 1000;
    localparam int SETTLE_CYCLES  = 20;    // settle time, covering a slide over up to 16 slots
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;  // cycles without any transfer

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [SEQ_FIELD_W-1:0] s_axis_tdata;   // [15:0] sequence_number
    logic                   s_axis_tuser;   // [0] operation
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;   // [15:0] window_base, [31:16] next_to_send,
                                            // [36:32] slid_count, [39:37] zero
    logic                   m_axis_tuser;   // [0] granted
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [SEQ_FIELD_W-1:0] window_base_now;
    int                     results_pending;
    int                     mismatch_count;

    bit                     no_idle;        // phase with no gaps on either side
    int                     items_sent;
    int                     span_now;       // effective window + 1, for picking offsets
    int                     quiet_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    sliding_window_arq_sender dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    swarq_window_checker window_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .window_base_now (window_base_now),
        .results_pending (results_pending),
        .mismatch_count  (mismatch_count)
    );

    // Drop valid and hold until every outstanding result has been taken.
    task automatic wait_results_drained();
        s_axis_tvalid = 1'b0;
        while (results_pending != 0)
            @(negedge clk);
    endtask

    // Register writes only with the block idle; a window write does not restart state.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        int w;
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        if (idx == REG_WINDOW)
        begin
            w = int'(val);
            if (w < 1)
                w = 1;
            if (w > WINDOW_MAX_DEF)
                w = WINDOW_MAX_DEF;
            span_now = w + 1;
        end
    endtask

    // One input transfer. Valid stays high on return so a zero gap keeps it asserted.
    task automatic send_item(input logic op, input logic [SEQ_FIELD_W-1:0] seq);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = seq;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
        items_sent++;
    endtask

    // Mostly numbers at or just past the base so that grants, acks and slides happen;
    // some just behind the base (modular wrap of the window test), some anywhere.
    task automatic random_item();
        int                     roll;
        logic                   op;
        logic [SEQ_FIELD_W-1:0] seq;
        if ($urandom_range(0, 49) == 0)
            wait_results_drained();
        roll = $urandom_range(0, 99);
        op   = ($urandom_range(0, 1) != 0) ? OP_ACK : OP_SEND;
        if (roll < 30)
            seq = window_base_now;
        else if (roll < 75)
            seq = window_base_now + SEQ_FIELD_W'($urandom_range(1, span_now));
        else if (roll < 85)
            seq = window_base_now - SEQ_FIELD_W'($urandom_range(1, 4));
        else
            seq = SEQ_FIELD_W'($urandom);
        send_item(op, seq);
    endtask

    // Result side: a fresh stall before each result, none in no-gap phases.
    initial
    begin : result_sink
        int stall;
        m_axis_tready = 1'b0;
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            @(negedge clk);
            m_axis_tready = 1'b0;
            repeat (stall) @(negedge clk);
            m_axis_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Watchdog: any stretch without a transfer on any channel this long is a hang.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] mode_sel;
        logic [CFG_DATA_W-1:0] wsize_sel;
        s_axis_tvalid = 1'b0;
        s_axis_tuser  = OP_SEND;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_MODE;
        cfg_data      = '0;
        no_idle       = 1'b0;
        items_sent    = 0;
        span_now      = int'(WSIZE_RESET) + 1;
        quiet_cycles  = 0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Go-back-n from reset (window 4, base = next = 1): fill the window, one refused
        // send, an ack behind the base, a cumulative ack, an ack at next, a single ack.
        send_item(OP_SEND, 16'h0000);
        send_item(OP_SEND, 16'hFFFF);
        send_item(OP_SEND, 16'h5A5A);
        send_item(OP_SEND, 16'hA5A5);
        send_item(OP_SEND, 16'h0001);
        send_item(OP_ACK, 16'h0000);
        send_item(OP_ACK, 16'h0003);
        send_item(OP_ACK, 16'h0005);
        send_item(OP_ACK, 16'h0004);

        // Stop-and-wait, smallest window: only the base number gets through.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SAW));
        write_reg(REG_WINDOW, CFG_DATA_W'(1));
        send_item(OP_SEND, 16'h0001);
        send_item(OP_SEND, 16'h0000);
        send_item(OP_ACK, 16'h0000);
        send_item(OP_ACK, 16'h0000);

        // Selective repeat with an oversize window (clamped to 16): out-of-order acks,
        // send of an acked slot, window edges, slide over three slots, ack behind the base.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_SR));
        write_reg(REG_WINDOW, CFG_DATA_W'(31));
        send_item(OP_ACK, 16'h0002);
        send_item(OP_ACK, 16'h0001);
        send_item(OP_SEND, 16'h0001);
        send_item(OP_SEND, 16'h000F);
        send_item(OP_SEND, 16'h0010);
        send_item(OP_ACK, 16'h0000);
        send_item(OP_ACK, 16'hFFFF);

        // Window size zero acts as one, without restarting the base.
        write_reg(REG_WINDOW, CFG_DATA_W'(0));
        send_item(OP_ACK, 16'h0004);
        send_item(OP_ACK, 16'h0003);

        // Unused mode: all refused, state held.
        write_reg(REG_MODE, CFG_DATA_W'(MODE_NONE));
        send_item(OP_SEND, 16'h0004);
        send_item(OP_ACK, 16'h0000);

        // Random phases, each with a new setting; window extremes drawn often.
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: mode_sel = CFG_DATA_W'(MODE_GBN);
                3, 4, 5: mode_sel = CFG_DATA_W'(MODE_SR);
                6, 7, 8: mode_sel = CFG_DATA_W'(MODE_SAW);
                default: mode_sel = CFG_DATA_W'(MODE_NONE);
            endcase
            case ($urandom_range(0, 9))
                0:       wsize_sel = CFG_DATA_W'(0);
                1:       wsize_sel = CFG_DATA_W'(1);
                2:       wsize_sel = CFG_DATA_W'(16);
                3:       wsize_sel = CFG_DATA_W'(17);
                4:       wsize_sel = CFG_DATA_W'(31);
                default: wsize_sel = CFG_DATA_W'($urandom_range(1, 16));
            endcase
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_WINDOW, wsize_sel);
            else if ($urandom_range(0, 1) != 0)
            begin
                write_reg(REG_MODE, mode_sel);
                write_reg(REG_WINDOW, wsize_sel);
            end
            else
            begin
                write_reg(REG_WINDOW, wsize_sel);
                write_reg(REG_MODE, mode_sel);
            end
            no_idle = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(30, 90)) random_item();
        end

        // Drain, let the pipeline settle, then decide.
        wait_results_drained();
        no_idle = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && results_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
`default_nettype wire
